[src/ffpa_pkg.sv]
// Shared types, codes and field widths for the first-fit page-run allocator.
package ffpa_pkg;

	localparam int USER_PAGE_COUNT_DEF = 512;
	localparam int PAGE_BYTES_DEF      = 4096;

	localparam int OP_W   = 2;
	localparam int SIZE_W = 22;
	localparam int ADDR_W = 23;
	localparam int BASE_W = 10;
	localparam int USED_W = 10;
	localparam int TAG_W  = 8;

	localparam logic [BASE_W-1:0] BASE_RST = 10'd530;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

	typedef struct packed {
		logic [USED_W-1:0] used_pages;
		logic [ADDR_W-1:0] block_address;
		logic              status;
	} res_t;

endpackage

[src/ffpa_owner_ram.sv]
// Owner map storage: one write port, one read port, registered read data.
module ffpa_owner_ram #(
	parameter int DEPTH = ffpa_pkg::USER_PAGE_COUNT_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [ffpa_pkg::TAG_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [ffpa_pkg::TAG_W-1:0] rd_data
);

	logic [ffpa_pkg::TAG_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/ffpa_ctrl.sv]
// Request sequencer: clear pass, first-fit scan, run fill and run free over the owner map.
module ffpa_ctrl #(
	parameter int USER_PAGE_COUNT = ffpa_pkg::USER_PAGE_COUNT_DEF,
	parameter int PAGE_BYTES      = ffpa_pkg::PAGE_BYTES_DEF,
	localparam int IDX_W = $clog2(USER_PAGE_COUNT)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ffpa_pkg::BASE_W-1:0] base_page,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [ffpa_pkg::OP_W-1:0]   req_op,
	input  logic [ffpa_pkg::SIZE_W-1:0] req_size,
	input  logic [ffpa_pkg::ADDR_W-1:0] req_addr,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ffpa_pkg::res_t              res,
	output logic                        mem_wr_en,
	output logic [IDX_W-1:0]            mem_wr_addr,
	output logic [ffpa_pkg::TAG_W-1:0]  mem_wr_data,
	output logic                        mem_rd_en,
	output logic [IDX_W-1:0]            mem_rd_addr,
	input  logic [ffpa_pkg::TAG_W-1:0]  mem_rd_data
);

	localparam int PB_SH  = $clog2(PAGE_BYTES);
	localparam int CNT_W  = $clog2(USER_PAGE_COUNT + 1);
	localparam int PGS_W  = ffpa_pkg::SIZE_W - PB_SH + 1;
	localparam int CMP_W  = (PGS_W > CNT_W ? PGS_W : CNT_W) + 1;
	localparam int PG_W   = ffpa_pkg::ADDR_W - PB_SH;
	localparam int DM_W   = PG_W > ffpa_pkg::BASE_W ? PG_W : ffpa_pkg::BASE_W;
	localparam int DEC_W  = (DM_W > CNT_W ? DM_W : CNT_W) + 1;
	localparam int SUM_W  = (IDX_W > ffpa_pkg::BASE_W ? IDX_W : ffpa_pkg::BASE_W) + 1;
	localparam int WIDE_W = SUM_W + PB_SH + ffpa_pkg::ADDR_W;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USER_PAGE_COUNT - 1);
	localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(USER_PAGE_COUNT);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_FREE  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]                 state_q;
	logic [CNT_W-1:0]           ptr_q;
	logic                       rd_vld_s1;
	logic [IDX_W-1:0]           rd_idx_s1;
	logic [CNT_W-1:0]           run_q;
	logic [CNT_W-1:0]           pages_q;
	logic [ffpa_pkg::TAG_W-1:0] tag_q;
	logic                       first_q;
	logic [IDX_W-1:0]           end_q;
	logic [IDX_W-1:0]           start_q;
	logic [ffpa_pkg::TAG_W-1:0] next_tag_q;
	logic [CNT_W-1:0]           used_q;
	logic                       status_q;
	logic [ffpa_pkg::ADDR_W-1:0] baddr_q;

	logic                 accept;
	logic [PGS_W-1:0]     pages_w;
	logic                 size_zero;
	logic                 too_big;
	logic [PG_W-1:0]      fpage;
	logic [DEC_W-1:0]     fidx;
	logic                 below_base;
	logic                 beyond_map;
	logic [CNT_W-1:0]     run_n;
	logic                 hit;
	logic [CNT_W:0]       start_x;
	logic                 tag_hit;
	logic [SUM_W-1:0]     page_sum;
	logic [WIDE_W-1:0]    byte_wide;
	logic [CNT_W+ffpa_pkg::USED_W-1:0] used_wide;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	// Round the byte size up to whole pages.
	assign pages_w   = PGS_W'(req_size >> PB_SH) + PGS_W'(|req_size[PB_SH-1:0]);
	assign size_zero = (req_size == '0);
	assign too_big   = CMP_W'(pages_w) > CMP_W'(USER_PAGE_COUNT);

	// Free address to map index.
	assign fpage      = PG_W'(req_addr >> PB_SH);
	assign below_base = DEC_W'(fpage) < DEC_W'(base_page);
	assign fidx       = DEC_W'(fpage) - DEC_W'(base_page);
	assign beyond_map = fidx >= DEC_W'(USER_PAGE_COUNT);

	assign run_n   = (mem_rd_data == '0) ? run_q + CNT_W'(1) : '0;
	assign hit     = (run_n == pages_q);
	assign start_x = (CNT_W+1)'(rd_idx_s1) + (CNT_W+1)'(1) - (CNT_W+1)'(run_n);
	assign tag_hit = first_q ? (mem_rd_data != '0) : (mem_rd_data == tag_q);

	assign page_sum  = SUM_W'(start_q) + SUM_W'(base_page);
	assign byte_wide = WIDE_W'(page_sum) << PB_SH;
	assign used_wide = (CNT_W+ffpa_pkg::USED_W)'(used_q);

	always_comb begin
		mem_rd_en   = ((state_q == ST_SCAN) || (state_q == ST_FREE)) && (ptr_q < N_CNT);
		mem_rd_addr = ptr_q[IDX_W-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = ptr_q[IDX_W-1:0];
		mem_wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			ST_FILL: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = next_tag_q;
			end
			ST_FREE: begin
				mem_wr_en   = rd_vld_s1 && tag_hit;
				mem_wr_addr = rd_idx_s1;
			end
			default: begin
				mem_wr_en = 1'b0;
			end
		endcase
	end

	assign res_valid         = (state_q == ST_DONE);
	assign res.status        = status_q;
	assign res.block_address = baddr_q;
	assign res.used_pages    = used_wide[ffpa_pkg::USED_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			ptr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			run_q      <= '0;
			first_q    <= 1'b0;
			next_tag_q <= ffpa_pkg::TAG_W'(1);
			used_q     <= '0;
		end else begin
			rd_vld_s1 <= mem_rd_en;
			case (state_q)
				ST_CLEAR: begin
					if (ptr_q[IDX_W-1:0] == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req_op)
							ffpa_pkg::OP_ALLOC: begin
								if (size_zero || too_big) begin
									state_q <= ST_DONE;
								end else begin
									ptr_q   <= '0;
									run_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							ffpa_pkg::OP_FREE: begin
								if (below_base || beyond_map) begin
									state_q <= ST_DONE;
								end else begin
									ptr_q   <= fidx[CNT_W-1:0];
									first_q <= 1'b1;
									state_q <= ST_FREE;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// rewind to the run start on a hit, else advance the read pointer
					if (rd_vld_s1 && hit) begin
						ptr_q <= CNT_W'(start_x[IDX_W-1:0]);
					end else if (mem_rd_en) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						run_q <= run_n;
						if (hit) begin
							state_q <= ST_FILL;
						end else if (rd_idx_s1 == LAST_IDX) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_FILL: begin
					used_q <= used_q + CNT_W'(1);
					if (ptr_q[IDX_W-1:0] == end_q) begin
						next_tag_q <= (next_tag_q == '1) ? ffpa_pkg::TAG_W'(1)
						                                 : next_tag_q + ffpa_pkg::TAG_W'(1);
						state_q    <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
				end
				ST_FREE: begin
					if (mem_rd_en) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						first_q <= 1'b0;
						if (tag_hit) begin
							used_q <= used_q - CNT_W'(1);
							if (rd_idx_s1 == LAST_IDX) begin
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= mem_rd_addr;
		if (accept) begin
			status_q <= (req_op != ffpa_pkg::OP_COUNT);
			baddr_q  <= '0;
			pages_q  <= CNT_W'(pages_w);
		end
		if ((state_q == ST_SCAN) && rd_vld_s1 && hit) begin
			end_q   <= rd_idx_s1;
			start_q <= start_x[IDX_W-1:0];
		end
		if ((state_q == ST_FILL) && (ptr_q[IDX_W-1:0] == end_q)) begin
			status_q <= 1'b0;
			baddr_q  <= byte_wide[ffpa_pkg::ADDR_W-1:0];
		end
		if ((state_q == ST_FREE) && rd_vld_s1 && first_q) begin
			tag_q <= mem_rd_data;
			if (tag_hit) begin
				status_q <= 1'b0;
			end
		end
	end

	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
		else $error("owner map read and write hit the same entry");

	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= N_CNT)
		else $error("used page count above map size");

	a_tag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_tag_q != '0)
		else $error("next tag is zero");

	a_free_has_used: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FREE) && rd_vld_s1 && tag_hit) |-> (used_q != '0))
		else $error("free clears a page while the used count is zero");

endmodule

[src/first_fit_page_run_allocator.sv]
// Top level of the first-fit page-run allocator: stream ports, base register, result stage.
//
// One request beat in, one result beat out. The owner map (one 8-bit tag per
// user page) sits in a single-port-write, single-port-read memory with
// registered read data, and allocate and free requests walk it one entry per
// cycle. After reset the block first zeroes the whole map and holds s_tready
// low until that pass is done; base_page writes are taken meanwhile. Allocate
// scans for the first free run that fits, reading one entry per cycle, then
// fills that run, writing one tag per cycle; a miss scans the whole map. Free
// clears forward from the given page while the owner tag matches, one clear
// per cycle. Zero-size or oversized allocates, and frees that fall below
// base_page or past the map, return without a map walk. The result sits in an
// output register, so the next request is accepted while an earlier result
// still waits on m_tready. Write base_page only while no request is outstanding.
module first_fit_page_run_allocator #(
	parameter int USER_PAGE_COUNT = ffpa_pkg::USER_PAGE_COUNT_DEF,
	parameter int PAGE_BYTES      = ffpa_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// base page register
	input  logic        cfg_wr_en,
	input  logic [9:0]  cfg_wr_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [21:0] size_bytes, [44:22] address, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [0] status, [23:1] block_address, [33:24] used_pages
);

	localparam int IDX_W = $clog2(USER_PAGE_COUNT);

	logic [ffpa_pkg::BASE_W-1:0] base_q;

	logic                       res_valid;
	logic                       res_ready;
	ffpa_pkg::res_t             res;
	ffpa_pkg::res_t             out_q;
	logic                       out_vld_q;

	logic                       mem_wr_en;
	logic [IDX_W-1:0]           mem_wr_addr;
	logic [ffpa_pkg::TAG_W-1:0] mem_wr_data;
	logic                       mem_rd_en;
	logic [IDX_W-1:0]           mem_rd_addr;
	logic [ffpa_pkg::TAG_W-1:0] mem_rd_data;

	// Base page register: plain write, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ffpa_pkg::BASE_RST;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	ffpa_ctrl #(
		.USER_PAGE_COUNT (USER_PAGE_COUNT),
		.PAGE_BYTES      (PAGE_BYTES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_page   (base_q),
		.req_valid   (s_tvalid),
		.req_ready   (s_tready),
		.req_op      (s_tuser),
		.req_size    (s_tdata[21:0]),
		.req_addr    (s_tdata[44:22]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	ffpa_owner_ram #(
		.DEPTH (USER_PAGE_COUNT)
	) u_owner_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Output stage: take a new result when empty or when the held beat leaves.
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_q.used_pages, out_q.block_address, out_q.status};

endmodule

[test/tb.sv]
// Self-checking testbench for the first-fit page-run allocator.
`timescale 1ns / 1ps

module tb;

	localparam logic [ffpa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int PHASE_ITEMS      = 280;
	localparam int LONG_HOLD_AT     = 500;
	localparam int LONG_HOLD_CYCLES = 1500;
	localparam int DRAIN_CYCLES     = 64;

	// Shadow of the owner map plus the queue of results it predicts.
	class owner_map_model;
		logic [ffpa_pkg::TAG_W-1:0]  owner_map [ffpa_pkg::USER_PAGE_COUNT_DEF];
		logic [ffpa_pkg::TAG_W-1:0]  next_tag;
		int unsigned                 used_count;
		logic [ffpa_pkg::BASE_W-1:0] base_page;
		ffpa_pkg::res_t              pending_results [$];
		int unsigned                 errors;

		function new();
			foreach (owner_map[i]) owner_map[i] = '0;
			next_tag   = 8'd1;
			used_count = 0;
			base_page  = ffpa_pkg::BASE_RST;
			errors     = 0;
		endfunction

		// Apply one accepted request; return the first page of a new run, or -1.
		function int note_request(input logic [ffpa_pkg::OP_W-1:0] op,
			input logic [ffpa_pkg::SIZE_W-1:0] size_bytes,
			input logic [ffpa_pkg::ADDR_W-1:0] address);
			ffpa_pkg::res_t             want;
			int                         start_page;
			int unsigned                pages, run, idx, page;
			logic [ffpa_pkg::TAG_W-1:0] tag;
			start_page  = -1;
			want        = '0;
			want.status = 1'b1;
			case (op)
				ffpa_pkg::OP_ALLOC: begin
					pages = (size_bytes + ffpa_pkg::PAGE_BYTES_DEF - 1)
						/ ffpa_pkg::PAGE_BYTES_DEF;
					if (size_bytes != 0 && pages <= ffpa_pkg::USER_PAGE_COUNT_DEF) begin
						run = 0;
						for (int i = 0; i < ffpa_pkg::USER_PAGE_COUNT_DEF && start_page < 0;
							i++) begin
							run = (owner_map[i] == 0) ? run + 1 : 0;
							if (run == pages) begin
								start_page = i + 1 - run;
								for (int j = start_page; j <= i; j++) owner_map[j] = next_tag;
								used_count += run;
								next_tag = (next_tag == 8'd255) ? 8'd1 : next_tag + 8'd1;
								want.status = 1'b0;
								want.block_address = ffpa_pkg::ADDR_W'(
									(start_page + base_page) * ffpa_pkg::PAGE_BYTES_DEF);
							end
						end
					end
				end
				ffpa_pkg::OP_FREE: begin
					page = address / ffpa_pkg::PAGE_BYTES_DEF;
					if (page >= base_page) begin
						idx = page - base_page;
						if (idx < ffpa_pkg::USER_PAGE_COUNT_DEF && owner_map[idx] != 0) begin
							// clear forward while the tag matches, up to the map end
							tag = owner_map[idx];
							while (idx < ffpa_pkg::USER_PAGE_COUNT_DEF
								&& owner_map[idx] == tag) begin
								owner_map[idx] = '0;
								used_count--;
								idx++;
							end
							want.status = 1'b0;
						end
					end
				end
				ffpa_pkg::OP_COUNT: want.status = 1'b0;
				default: want.status = 1'b1;
			endcase
			want.used_pages = ffpa_pkg::USED_W'(used_count);
			pending_results.push_back(want);
			return start_page;
		endfunction

		function void check_result(input logic [39:0] beat);
			ffpa_pkg::res_t got, want;
			got = beat[$bits(ffpa_pkg::res_t)-1:0];
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected: %h", $time, beat);
				return;
			end
			want = pending_results.pop_front();
			if (got.status != want.status) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			end
			if (got.block_address != want.block_address) begin
				errors++;
				$display("%0t: block_address expected %h actual %h", $time,
					want.block_address, got.block_address);
			end
			if (got.used_pages != want.used_pages) begin
				errors++;
				$display("%0t: used_pages expected %0d actual %0d", $time,
					want.used_pages, got.used_pages);
			end
		endfunction
	endclass

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_wr_en   = 1'b0;
	logic [ffpa_pkg::BASE_W-1:0] cfg_wr_data = '0;
	logic                        s_tvalid    = 1'b0;
	logic                        s_tready;
	logic [47:0]                 s_tdata     = '0;   // [21:0] size_bytes, [44:22] address, rest zero
	logic [1:0]                  s_tuser     = '0;   // [1:0] operation
	logic                        m_tvalid;
	logic                        m_tready    = 1'b0;
	logic [39:0]                 m_tdata;            // [0] status, [23:1] block_address, [33:24] used_pages

	owner_map_model run_map = new();
	int             live_start [$];
	int             live_len [$];
	int unsigned    sent_count    = 0;
	int unsigned    results_taken = 0;
	bit             rx_long_hold  = 1'b0;

	first_fit_page_run_allocator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [ffpa_pkg::ADDR_W-1:0] page_addr(input int page);
		return ffpa_pkg::ADDR_W'((run_map.base_page + page) * ffpa_pkg::PAGE_BYTES_DEF);
	endfunction

	// Offer one request beat after a random gap; hold until it is taken.
	task automatic send_request(input logic [ffpa_pkg::OP_W-1:0] op,
		input logic [ffpa_pkg::SIZE_W-1:0] size_bytes,
		input logic [ffpa_pkg::ADDR_W-1:0] address);
		int gap;
		int start_page;
		gap = (rx_long_hold || (sent_count / 40) % 5 == 4) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, address, size_bytes};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
		start_page = run_map.note_request(op, size_bytes, address);
		if (start_page >= 0) begin
			live_start.push_back(start_page);
			live_len.push_back((size_bytes + ffpa_pkg::PAGE_BYTES_DEF - 1)
				/ ffpa_pkg::PAGE_BYTES_DEF);
		end
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (run_map.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_base(input logic [ffpa_pkg::BASE_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		run_map.base_page = value;
	endtask

	task automatic random_request();
		int                          pick, k, page;
		logic [ffpa_pkg::OP_W-1:0]   op;
		logic [ffpa_pkg::SIZE_W-1:0] size_bytes;
		logic [ffpa_pkg::ADDR_W-1:0] address;
		pick       = $urandom_range(0, 99);
		size_bytes = ffpa_pkg::SIZE_W'($urandom);
		address    = ffpa_pkg::ADDR_W'($urandom);
		if (pick < 45) begin
			op = ffpa_pkg::OP_ALLOC;
			k  = $urandom_range(0, 19);
			// mostly short runs, a few long ones, some raw and zero sizes
			if (k < 14)
				size_bytes = ffpa_pkg::SIZE_W'(
					$urandom_range(1, 8 * ffpa_pkg::PAGE_BYTES_DEF));
			else if (k < 16)
				size_bytes = ffpa_pkg::SIZE_W'(
					$urandom_range(1, 64 * ffpa_pkg::PAGE_BYTES_DEF));
			else if (k < 17)
				size_bytes = ffpa_pkg::SIZE_W'($urandom_range(0,
					ffpa_pkg::USER_PAGE_COUNT_DEF * ffpa_pkg::PAGE_BYTES_DEF));
			else if (k == 19)
				size_bytes = '0;
		end else if (pick < 85) begin
			op = ffpa_pkg::OP_FREE;
			if (live_start.size() > 0 && $urandom_range(0, 4) != 0) begin
				k    = $urandom_range(0, live_start.size() - 1);
				page = live_start[k];
				if ($urandom_range(0, 7) == 0) page += $urandom_range(0, live_len[k] - 1);
				address = ffpa_pkg::ADDR_W'(page_addr(page)
					+ $urandom_range(0, ffpa_pkg::PAGE_BYTES_DEF - 1));
				live_start.delete(k);
				live_len.delete(k);
			end else if ($urandom_range(0, 1) == 0) begin
				// sweep pages around the map, leaked runs included
				address = ffpa_pkg::ADDR_W'(
					page_addr($urandom_range(0, ffpa_pkg::USER_PAGE_COUNT_DEF + 8))
					+ $urandom_range(0, ffpa_pkg::PAGE_BYTES_DEF - 1));
			end
		end else if (pick < 95) begin
			op = ffpa_pkg::OP_COUNT;
		end else begin
			op = OP_UNUSED;
		end
		send_request(op, size_bytes, address);
	endtask

	// Result side: random back-pressure, one long hold-off to fill the block.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ((results_taken / 40) % 5 == 1) ? 0 : $urandom_range(0, 11);
			if (results_taken == LONG_HOLD_AT) begin
				rx_long_hold = 1'b1;
				gap = LONG_HOLD_CYCLES;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rx_long_hold = 1'b0;
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_taken++;
			run_map.check_result(m_tdata);
		end
	end

	initial begin
		logic [ffpa_pkg::BASE_W-1:0] phase_base [4];
		phase_base[0] = '0;
		phase_base[1] = '1;
		phase_base[2] = ffpa_pkg::BASE_W'($urandom);
		phase_base[3] = ffpa_pkg::BASE_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base(ffpa_pkg::BASE_RST);

		// directed: size extremes, every operation, each failing free
		send_request(ffpa_pkg::OP_COUNT, '0, '0);
		send_request(ffpa_pkg::OP_ALLOC, '0, '1);
		send_request(ffpa_pkg::OP_ALLOC, '1, '0);
		send_request(ffpa_pkg::OP_ALLOC, 22'd1, '0);
		send_request(ffpa_pkg::OP_ALLOC, 22'd4096, '0);
		send_request(ffpa_pkg::OP_ALLOC, 22'd4097, '0);
		send_request(ffpa_pkg::OP_ALLOC, 22'd12288, '0);
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(5) + 23'd123);
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(5));
		send_request(ffpa_pkg::OP_FREE, '1, '0);
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(ffpa_pkg::USER_PAGE_COUNT_DEF));
		send_request(ffpa_pkg::OP_FREE, '0, '1);
		send_request(OP_UNUSED, '1, '1);
		send_request(ffpa_pkg::OP_ALLOC,
			ffpa_pkg::SIZE_W'(ffpa_pkg::USER_PAGE_COUNT_DEF * ffpa_pkg::PAGE_BYTES_DEF), '0);
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(0));
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(1));
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(2) + 23'd4095);
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(4));
		send_request(ffpa_pkg::OP_ALLOC,
			ffpa_pkg::SIZE_W'(ffpa_pkg::USER_PAGE_COUNT_DEF * ffpa_pkg::PAGE_BYTES_DEF), '0);
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(ffpa_pkg::USER_PAGE_COUNT_DEF - 1));
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(300));
		send_request(ffpa_pkg::OP_FREE, '0, page_addr(0));
		send_request(ffpa_pkg::OP_COUNT, '1, '1);

		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_base(phase_base[p]);
			repeat (PHASE_ITEMS) random_request();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (run_map.errors == 0 && run_map.pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[files.f]
src/ffpa_pkg.sv
src/ffpa_owner_ram.sv
src/ffpa_ctrl.sv
src/first_fit_page_run_allocator.sv
test/tb.sv
